// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the middle insert queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Same-cycle implication outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg)
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/miq_pkg.sv =====
// Constants, codes and ring helpers for the middle insert queue.
`default_nettype none
package miq_pkg;
  localparam int HALF_DEPTH = 1024;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_W     = (HALF_DEPTH > 1) ? $clog2(HALF_DEPTH) : 1;
  localparam int CNT_W      = $clog2(HALF_DEPTH + 1);
  localparam int TOTAL_W    = CNT_W + 1;

  localparam int IN_VALUE_W  = 32;
  localparam int STATUS_W    = 2;
  localparam int POPPED_W    = 32;
  localparam int OUT_TOTAL_W = 12;

  typedef logic [DATA_WIDTH-1:0] data_t;
  typedef logic [ADDR_W-1:0]     addr_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [TOTAL_W-1:0]    total_t;
  typedef logic [1:0]            mode_t;
  typedef logic [STATUS_W-1:0]   status_t;

  localparam mode_t MODE_PUSH   = 2'd0;
  localparam mode_t MODE_INSERT = 2'd1;

  localparam status_t ST_STORED = 2'd0;
  localparam status_t ST_POPPED = 2'd1;
  localparam status_t ST_FULL   = 2'd2;
  localparam status_t ST_EMPTY  = 2'd3;

  localparam total_t TOTAL_MAX = total_t'(2 * HALF_DEPTH);

  // Slot that sits cnt entries past head, wrapped once.
  function automatic addr_t ring_add(input addr_t head, input cnt_t cnt);
    logic [CNT_W:0] sum;
    sum = (CNT_W + 1)'(head) + (CNT_W + 1)'(cnt);
    if (sum >= (CNT_W + 1)'(HALF_DEPTH)) begin
      sum = sum - (CNT_W + 1)'(HALF_DEPTH);
    end
    return addr_t'(sum);
  endfunction

  function automatic addr_t ring_next(input addr_t idx);
    if ((CNT_W + 1)'(idx) + (CNT_W + 1)'(1) >= (CNT_W + 1)'(HALF_DEPTH)) begin
      return '0;
    end
    return idx + addr_t'(1);
  endfunction

  function automatic addr_t ring_prev(input addr_t idx);
    if (idx == '0) begin
      return addr_t'(HALF_DEPTH - 1);
    end
    return idx - addr_t'(1);
  endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/middle_insert_queue.sv =====
// Queue with push at back, insert at middle and pop at front.
// Usage:
//   Input channel in_valid/in_stall carries in_mode (0 push, 1 insert at
//   middle, 2 or 3 pop) and in_value. Every command yields one result on
//   out_valid/out_stall: out_status, out_popped_value, out_total_count.
//   The queue holds two halves of HALF_DEPTH entries each, one RAM per half.
//   A command is handled as a read and then a write: the transfer edge
//   reads both halves' head entries; once the output register is free,
//   the execute edge writes back at most one entry per half, updates the
//   ring pointers and loads the output register. The registered read of
//   the half RAMs sets this order, and in_stall stays high until the
//   command has executed, so commands do not overlap. A new command is
//   taken while the previous result still sits in the output register;
//   if the receiver holds out_stall, the block finishes the read and then
//   waits with in_stall high until the output register frees.
//   Reset clears the ring pointers, counts and output valid; the RAM
//   contents are left as they are, and no clearing pass is needed since only
//   live entries are ever read.
`default_nettype none
module middle_insert_queue (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output      logic                                in_stall,
  input  wire logic [1:0]                          in_mode,
  input  wire logic signed [miq_pkg::IN_VALUE_W-1:0] in_value,
  output      logic                                out_valid,
  input  wire logic                                out_stall,
  output      logic [miq_pkg::STATUS_W-1:0]        out_status,
  output      logic signed [miq_pkg::POPPED_W-1:0] out_popped_value,
  output      logic [miq_pkg::OUT_TOTAL_W-1:0]     out_total_count
);
  import miq_pkg::*;

  `include "assert_macros.svh"

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic    state_r, state_nxt;
  mode_t   mode_r;
  data_t   value_r;
  addr_t   f_head_r, f_head_nxt, b_head_r, b_head_nxt;
  cnt_t    f_cnt_r, f_cnt_nxt, b_cnt_r, b_cnt_nxt;
  logic    out_valid_r, out_valid_nxt;
  status_t out_status_r, status_nxt;
  logic [POPPED_W-1:0]    out_popped_r, popped_nxt;
  logic [OUT_TOTAL_W-1:0] out_total_r;

  logic   in_xfer, exec_go, is_full, balanced, is_pop;
  data_t  f_rd_data, b_rd_data, moved;
  logic   f_wr_en, b_wr_en;
  addr_t  f_wr_addr, b_wr_addr;
  data_t  f_wr_data, b_wr_data;
  total_t total_nxt;

  assign in_stall = (state_r != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign exec_go  = (state_r == S_EXEC) && (!out_valid_r || !out_stall);

  miq_ram #(.DEPTH(HALF_DEPTH), .WIDTH(DATA_WIDTH)) u_front_ram (
    .clk     (clk),
    .wr_en   (f_wr_en),
    .wr_addr (f_wr_addr),
    .wr_data (f_wr_data),
    .rd_en   (in_xfer),
    .rd_addr (f_head_r),
    .rd_data (f_rd_data)
  );

  miq_ram #(.DEPTH(HALF_DEPTH), .WIDTH(DATA_WIDTH)) u_back_ram (
    .clk     (clk),
    .wr_en   (b_wr_en),
    .wr_addr (b_wr_addr),
    .wr_data (b_wr_data),
    .rd_en   (in_xfer),
    .rd_addr (b_head_r),
    .rd_data (b_rd_data)
  );

  assign is_full  = ((TOTAL_W)'(f_cnt_r) + (TOTAL_W)'(b_cnt_r)) == TOTAL_MAX;
  assign balanced = (f_cnt_r == b_cnt_r);
  assign is_pop   = (mode_r != MODE_PUSH) && (mode_r != MODE_INSERT);
  // Forward the pushed value when the back half was empty.
  assign moved    = (b_cnt_r == '0) ? value_r : b_rd_data;

  always_comb begin
    f_head_nxt = f_head_r;
    b_head_nxt = b_head_r;
    f_cnt_nxt  = f_cnt_r;
    b_cnt_nxt  = b_cnt_r;
    f_wr_en    = 1'b0;
    b_wr_en    = 1'b0;
    f_wr_addr  = ring_add(f_head_r, f_cnt_r);
    b_wr_addr  = ring_add(b_head_r, b_cnt_r);
    f_wr_data  = value_r;
    b_wr_data  = value_r;
    status_nxt = ST_STORED;
    popped_nxt = '0;
    if (exec_go) begin
      if (is_pop) begin
        if (f_cnt_r == '0) begin
          status_nxt = ST_EMPTY;
        end else begin
          status_nxt = ST_POPPED;
          popped_nxt = POPPED_W'(f_rd_data);
          f_head_nxt = ring_next(f_head_r);
          if (balanced) begin
            // Refill the front tail from the back head.
            f_wr_en    = 1'b1;
            f_wr_data  = b_rd_data;
            b_head_nxt = ring_next(b_head_r);
            b_cnt_nxt  = b_cnt_r - cnt_t'(1);
          end else begin
            f_cnt_nxt = f_cnt_r - cnt_t'(1);
          end
        end
      end else if (is_full) begin
        status_nxt = ST_FULL;
      end else if (mode_r == MODE_PUSH) begin
        b_wr_en = 1'b1;
        if (balanced) begin
          f_wr_en    = 1'b1;
          f_wr_data  = moved;
          f_cnt_nxt  = f_cnt_r + cnt_t'(1);
          b_head_nxt = ring_next(b_head_r);
        end else begin
          b_cnt_nxt = b_cnt_r + cnt_t'(1);
        end
      end else begin
        // Insert at the middle goes straight to the front tail when balanced.
        if (balanced) begin
          f_wr_en   = 1'b1;
          f_cnt_nxt = f_cnt_r + cnt_t'(1);
        end else begin
          b_wr_en    = 1'b1;
          b_wr_addr  = ring_prev(b_head_r);
          b_head_nxt = ring_prev(b_head_r);
          b_cnt_nxt  = b_cnt_r + cnt_t'(1);
        end
      end
    end
  end

  assign total_nxt = (TOTAL_W)'(f_cnt_nxt) + (TOTAL_W)'(b_cnt_nxt);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_xfer) state_nxt = S_EXEC;
      S_EXEC: if (exec_go) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (exec_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      f_head_r    <= '0;
      b_head_r    <= '0;
      f_cnt_r     <= '0;
      b_cnt_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      f_head_r    <= f_head_nxt;
      b_head_r    <= b_head_nxt;
      f_cnt_r     <= f_cnt_nxt;
      b_cnt_r     <= b_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      mode_r  <= in_mode;
      value_r <= DATA_WIDTH'($unsigned(in_value));
    end
    if (exec_go) begin
      out_status_r <= status_nxt;
      out_popped_r <= popped_nxt;
      out_total_r  <= OUT_TOTAL_W'(total_nxt);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_popped_value = $signed(out_popped_r);
  assign out_total_count  = out_total_r;

  `ASSERT_ALWAYS(a_halves_balanced, clk, rst_n, (f_cnt_r == b_cnt_r) || (f_cnt_r == b_cnt_r + cnt_t'(1)), "halves out of balance")
  `ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_xfer, in_stall && (state_r == S_EXEC), "second command taken while one is in flight")
  `ASSERT_IMPLY(a_empty_count, clk, rst_n, out_valid_r && (out_status_r == ST_EMPTY), out_total_r == '0, "pop on empty with entries held")
  `ASSERT_IMPLY(a_full_count, clk, rst_n, out_valid_r && (out_status_r == ST_FULL), out_total_r == OUT_TOTAL_W'(TOTAL_MAX), "drop reported below full")
endmodule
`default_nettype wire

// ===== hw/rtl/miq_ram.sv =====
// Simple dual-port RAM, one write and one registered read per cycle.
`default_nettype none
module miq_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  wire logic                                        clk,
  input  wire logic                                        wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                            wr_data,
  input  wire logic                                        rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output      logic [WIDTH-1:0]                            rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule
`default_nettype wire

// ===== dv/miq_checker.sv =====
`timescale 1ns / 1ps
// Checker that predicts every middle insert queue result and scores the outputs.
module miq_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [1:0]                      in_mode,
  input  logic [miq_pkg::IN_VALUE_W-1:0]  in_value,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [miq_pkg::STATUS_W-1:0]    out_status,
  input  logic [miq_pkg::POPPED_W-1:0]    out_popped_value,
  input  logic [miq_pkg::OUT_TOTAL_W-1:0] out_total_count,
  output int                              mismatches,
  output int                              pending_results,
  output int                              full_seen,
  output int                              empty_seen
);
  import miq_pkg::*;

  typedef struct packed {
    status_t                status;
    logic [POPPED_W-1:0]    popped;
    logic [OUT_TOTAL_W-1:0] total;
  } cmd_result_t;

  // Shadow copy of the two halves.
  data_t front_ring [HALF_DEPTH];
  data_t back_ring  [HALF_DEPTH];
  int    front_first = 0;
  int    front_len   = 0;
  int    back_first  = 0;
  int    back_len    = 0;

  cmd_result_t expected_results [$];
  int          error_tally = 0;
  int          full_tally  = 0;
  int          empty_tally = 0;

  assign mismatches = error_tally;
  assign full_seen  = full_tally;
  assign empty_seen = empty_tally;

  function automatic cmd_result_t apply_command(input mode_t m,
                                                input logic [IN_VALUE_W-1:0] v);
    cmd_result_t r;
    r = '0;
    if (m == MODE_PUSH || m == MODE_INSERT) begin
      if (front_len + back_len >= 2 * HALF_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        if (m == MODE_PUSH) begin
          back_ring[(back_first + back_len) % HALF_DEPTH] = data_t'(v);
        end else begin
          back_first = (back_first + HALF_DEPTH - 1) % HALF_DEPTH;
          back_ring[back_first] = data_t'(v);
        end
        back_len++;
        r.status = ST_STORED;
      end
    end else if (front_len == 0) begin
      // any other mode code is a pop
      r.status = ST_EMPTY;
    end else begin
      r.popped   = POPPED_W'(front_ring[front_first]);
      front_first = (front_first + 1) % HALF_DEPTH;
      front_len--;
      r.status   = ST_POPPED;
    end
    // keep the front half as long as the back half or one longer
    if (front_len < back_len) begin
      front_ring[(front_first + front_len) % HALF_DEPTH] = back_ring[back_first];
      back_first = (back_first + 1) % HALF_DEPTH;
      back_len--;
      front_len++;
    end
    r.total = OUT_TOTAL_W'(front_len + back_len);
    return r;
  endfunction

  always @(posedge clk) begin
    cmd_result_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t ns: result with nothing expected: status %0d, popped %0h, count %0d",
                   $time, out_status, out_popped_value, out_total_count);
          error_tally++;
        end else begin
          want = expected_results.pop_front();
          if (out_status !== want.status) begin
            $display("%0t ns: status expected %0d, got %0d", $time, want.status, out_status);
            error_tally++;
          end
          if (out_popped_value !== want.popped) begin
            $display("%0t ns: popped value expected %0h, got %0h",
                     $time, want.popped, out_popped_value);
            error_tally++;
          end
          if (out_total_count !== want.total) begin
            $display("%0t ns: total count expected %0d, got %0d",
                     $time, want.total, out_total_count);
            error_tally++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        want = apply_command(in_mode, in_value);
        if (want.status == ST_FULL) full_tally++;
        if (want.status == ST_EMPTY) empty_tally++;
        expected_results.push_back(want);
      end
    end
    pending_results <= expected_results.size();
  end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// Testbench top: clock, reset, command stimulus in phases and the final verdict.
module testbench;
  import miq_pkg::*;

  localparam mode_t MODE_POP   = 2'd2;
  localparam mode_t MODE_SPARE = 2'd3;  // unassigned code, decoded as a pop
  localparam int    LONG_HOLD     = 300;
  localparam int    SETTLE_CYCLES = 20;

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   in_valid  = 1'b0;
  logic                   in_stall;
  logic [1:0]             in_mode   = '0;
  logic [IN_VALUE_W-1:0]  in_value  = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [STATUS_W-1:0]    out_status;
  logic [POPPED_W-1:0]    out_popped_value;
  logic [OUT_TOTAL_W-1:0] out_total_count;

  int mismatches;
  int pending_results;
  int full_seen;
  int empty_seen;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_requests  = 0;
  int hold_seen      = 0;
  int hold_left      = 0;
  int stores_sent    = 0;
  int pops_sent      = 0;

  middle_insert_queue dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_popped_value (out_popped_value),
    .out_total_count  (out_total_count)
  );

  miq_checker result_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_popped_value (out_popped_value),
    .out_total_count  (out_total_count),
    .mismatches       (mismatches),
    .pending_results  (pending_results),
    .full_seen        (full_seen),
    .empty_seen       (empty_seen)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_seen != hold_requests) begin
      hold_seen = hold_requests;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  task automatic send_command(input mode_t m, input logic [IN_VALUE_W-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode  <= m;
    in_value <= v;
    // hold the payload until the transfer
    do @(posedge clk); while (in_stall);
    if (m == MODE_PUSH || m == MODE_INSERT) stores_sent++;
    else pops_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
  endtask

  function automatic mode_t pick_mode(input int store_pct);
    if ($urandom_range(99) < store_pct) return $urandom_range(1) ? MODE_INSERT : MODE_PUSH;
    return ($urandom_range(7) == 0) ? MODE_SPARE : MODE_POP;
  endfunction

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty pops, value extremes, middle inserts, drain past empty.
    send_command(MODE_POP, '0);
    send_command(MODE_SPARE, 32'hFFFF_FFFF);
    send_command(MODE_PUSH, 32'h7FFF_FFFF);
    send_command(MODE_PUSH, 32'h8000_0000);
    send_command(MODE_INSERT, 32'h0000_0000);
    send_command(MODE_PUSH, 32'hFFFF_FFFF);
    send_command(MODE_INSERT, 32'h5555_5555);
    send_command(MODE_INSERT, 32'hAAAA_AAAA);
    send_command(MODE_POP, 32'h1234_5678);
    send_command(MODE_INSERT, 32'h0000_0001);
    send_command(MODE_SPARE, '0);
    send_command(MODE_PUSH, 32'hFFFF_FFFE);
    send_command(MODE_POP, '0);
    send_command(MODE_POP, '0);
    send_command(MODE_INSERT, 32'h8000_0001);
    repeat (6) send_command(MODE_POP, '0);
    send_command(MODE_SPARE, '0);
    send_command(MODE_POP, '0);
    wait_drained();

    // Balanced traffic around empty, idling on both sides.
    send_idle_pct  = 24;
    recv_stall_pct = 67;
    repeat (250) send_command(pick_mode(50), $urandom);
    wait_drained();
    send_idle_pct  = 67;
    recv_stall_pct = 24;
    repeat (250) send_command(pick_mode(50), $urandom);
    wait_drained();

    // Fill deep with no idling; open with a long receiver hold-off.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_requests++;
    repeat (550) send_command(pick_mode(100), $urandom);
    repeat (100) send_command(pick_mode(50), $urandom);
    wait_drained();

    // Drain past empty.
    hold_requests++;
    repeat (650) send_command(pick_mode(0), $urandom);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (pending_results != 0) begin
      $display("%0t ns: %0d expected results never arrived", $time, pending_results);
    end
    $display("Sent %0d push/insert and %0d pop commands through idle, stall and hold phases.",
             stores_sent, pops_sent);
    $display("Queue reported full %0d times and empty %0d times.", full_seen, empty_seen);
    if (mismatches == 0 && pending_results == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
